// ===== rtl/uart_baud_divider_search_unit_assert.svh =====
// Assertion macros shared by the baud divider search RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef UART_BAUD_DIVIDER_SEARCH_UNIT_ASSERT_SVH
`define UART_BAUD_DIVIDER_SEARCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define UBDS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubds assertion failed");
// Next-cycle implication, checked out of reset.
`define UBDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubds assertion failed");
`else
`define UBDS_ASSERT_IMPL(label, ante, cons)
`define UBDS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/ubds_pkg.sv =====
// Shared types and constants for the UART baud divider search unit.
// No dependencies.
package ubds_pkg;

    localparam int CLOCK_BITS_DEF = 27;
    localparam int FRAME_BITS     = 11;
    localparam int PAT_BITS       = 8;
    localparam int HEAD_BITS      = FRAME_BITS - PAT_BITS;
    localparam int NUM_HEADS      = 1 << HEAD_BITS;
    localparam int OVERSAMPLE_MIN = 20;
    localparam int MAX_QUOTIENT   = 65535;
    localparam int PRE_W          = 16;
    localparam int FM_W           = 4;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAUD_ZERO  = 2'd1,
        ST_BAUD_ABOVE = 2'd2,
        ST_OVERFLOW   = 2'd3
    } status_t;

    typedef struct packed {
        status_t          status;
        logic             over_sampling;
        logic [PRE_W-1:0] prescaler;
        logic [FM_W-1:0]  first_mod;
    } meta_t;

endpackage

// ===== rtl/uart_baud_divider_search_unit.sv =====
// Top level of the UART baud divider search unit.
// Depends on ubds_pkg, ubds_div, ubds_search and the assertion macro header.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   clock_hz, baud_hz
//   output    out_valid / out_ready status, over_sampling, prescaler, first_mod, second_mod
//
// One transfer is taken every cycle while the output is not stalled. The divider
// resolves one quotient bit per stage, then fourteen stages build the error table,
// run the backward and forward passes of the pattern search, and hold the result.
// Reset (rst_n, asynchronous) clears only the valid bits of the pipeline.
// When a result waits unaccepted at the output, every stage holds and in_ready drops.
`include "uart_baud_divider_search_unit_assert.svh"

module uart_baud_divider_search_unit
    import ubds_pkg::*;
#(
    parameter int CLOCK_BITS = CLOCK_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CLOCK_BITS-1:0] clock_hz,
    input  logic [CLOCK_BITS-1:0] baud_hz,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic                  over_sampling,
    output logic [PRE_W-1:0]      prescaler,
    output logic [FM_W-1:0]       first_mod,
    output logic [PAT_BITS-1:0]   second_mod
);

    // The whole pipeline moves together; it only stops when the final
    // result register is full and the downstream side refuses the transfer.
    logic                  adv;
    logic                  div_valid;
    meta_t                 div_meta;
    logic [CLOCK_BITS-1:0] div_rem;
    logic [CLOCK_BITS-1:0] div_den;
    meta_t                 res_meta;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Integer quotient and remainder; the remainder drives all timing errors,
    // since each bit error reduces to |k*rem - c*baud|.
    ubds_div #(
        .CLOCK_BITS (CLOCK_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .clock_hz  (clock_hz),
        .baud_hz   (baud_hz),
        .out_valid (div_valid),
        .out_meta  (div_meta),
        .rem       (div_rem),
        .den       (div_den)
    );

    // Exact min-max search over all modulation patterns, organized as a
    // dynamic program over pattern bits so no pattern is enumerated.
    ubds_search #(
        .CLOCK_BITS (CLOCK_BITS)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (div_valid),
        .in_meta    (div_meta),
        .rem        (div_rem),
        .den        (div_den),
        .out_valid  (out_valid),
        .out_meta   (res_meta),
        .second_mod (second_mod)
    );

    assign status        = res_meta.status;
    assign over_sampling = res_meta.over_sampling;
    assign prescaler     = res_meta.prescaler;
    assign first_mod     = res_meta.first_mod;

    // Error results carry no settings.
    `UBDS_ASSERT_IMPL(a_err_clear, out_valid && (status != ST_OK), (prescaler == '0) && (second_mod == '0) && !over_sampling && (first_mod == '0))
    // Oversampling needs a quotient of at least twenty, so the prescaler is nonzero.
    `UBDS_ASSERT_IMPL(a_os_pre, out_valid && (status == ST_OK) && over_sampling, prescaler != '0)
    // Without oversampling the prescaler is the small quotient itself.
    `UBDS_ASSERT_IMPL(a_plain, out_valid && (status == ST_OK) && !over_sampling, (first_mod == '0) && (prescaler != '0) && (prescaler < PRE_W'(OVERSAMPLE_MIN)))
    // A refused result freezes the pipeline, so no new transfer is taken.
    `UBDS_ASSERT_NEXT(a_stall, out_valid && !out_ready, out_valid && (in_ready == out_ready))

endmodule

// ===== rtl/ubds_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, then the divider settings.
// Depends on ubds_pkg.
module ubds_div
    import ubds_pkg::*;
#(
    parameter int CLOCK_BITS = CLOCK_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [CLOCK_BITS-1:0] clock_hz,
    input  logic [CLOCK_BITS-1:0] baud_hz,
    output logic                  out_valid,
    output meta_t                 out_meta,
    output logic [CLOCK_BITS-1:0] rem,
    output logic [CLOCK_BITS-1:0] den
);

    localparam int CB = CLOCK_BITS;

    logic [CB-1:0] vld_reg;
    logic [CB-1:0] rem_reg [CB];
    logic [CB-1:0] quo_reg [CB];
    logic [CB-1:0] den_reg [CB];
    logic [CB-1:0] num_reg [CB-1];
    status_t       st_reg  [CB];
    logic [CB-1:0] n_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[CB-2:0], in_valid};
        end
    end

    for (genvar s = 0; s < CB; s++)
    begin : g_stage
        logic [CB-1:0] rem_in;
        logic [CB-1:0] quo_in;
        logic [CB-1:0] num_in;
        logic [CB-1:0] den_in;
        status_t       st_in;
        logic [CB:0]   trial;
        logic          ge;
        logic [CB-1:0] quo_next;
        logic [CB-1:0] rem_next;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign num_in = clock_hz;
            assign den_in = baud_hz;
            assign st_in  = (baud_hz == '0) ? ST_BAUD_ZERO :
                            (baud_hz > clock_hz) ? ST_BAUD_ABOVE : ST_OK;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign num_in = num_reg[s-1];
            assign den_in = den_reg[s-1];
            assign st_in  = st_reg[s-1];
        end

        assign trial = {rem_in, num_in[CB-1-s]};
        assign ge    = (trial >= {1'b0, den_in});

        always_comb
        begin
            quo_next         = quo_in;
            quo_next[CB-1-s] = ge;
            rem_next         = ge ? CB'(trial - {1'b0, den_in}) : trial[CB-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
                den_reg[s] <= den_in;
                st_reg[s]  <= st_in;
            end
        end

        if (s < CB - 1)
        begin : g_num
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    num_reg[s] <= num_in;
                end
            end
        end
    end

    assign n_q       = quo_reg[CB-1];
    assign rem       = rem_reg[CB-1];
    assign den       = den_reg[CB-1];
    assign out_valid = vld_reg[CB-1];

    // Quotient range check and the oversampling split.
    always_comb
    begin
        out_meta.status        = st_reg[CB-1];
        out_meta.over_sampling = 1'b0;
        out_meta.prescaler     = '0;
        out_meta.first_mod     = '0;
        if (st_reg[CB-1] == ST_OK)
        begin
            if (n_q > CB'(MAX_QUOTIENT))
            begin
                out_meta.status = ST_OVERFLOW;
            end
            else if (n_q >= CB'(OVERSAMPLE_MIN))
            begin
                out_meta.over_sampling = 1'b1;
                out_meta.prescaler     = PRE_W'(n_q >> 4);
                out_meta.first_mod     = n_q[FM_W-1:0];
            end
            else
            begin
                out_meta.prescaler = PRE_W'(n_q);
            end
        end
    end

endmodule

// ===== rtl/ubds_search.sv =====
// Pipelined min-max search for the second modulation pattern.
// Depends on ubds_pkg.
module ubds_search
    import ubds_pkg::*;
#(
    parameter int CLOCK_BITS = CLOCK_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  meta_t                 in_meta,
    input  logic [CLOCK_BITS-1:0] rem,
    input  logic [CLOCK_BITS-1:0] den,
    output logic                  out_valid,
    output meta_t                 out_meta,
    output logic [PAT_BITS-1:0]   second_mod
);

    localparam int EW     = CLOCK_BITS + 4;
    localparam int NK     = FRAME_BITS;
    localparam int NC     = FRAME_BITS + 1;
    localparam int CW     = $clog2(NC);
    localparam int BACK   = PAT_BITS - HEAD_BITS;
    localparam int LEVELS = BACK + 1;
    localparam int SBK0   = 2;
    localparam int ST     = SBK0 + BACK;
    localparam int SS     = ST + 1;
    localparam int SF0    = SS + 1;
    localparam int NSTG   = SF0 + BACK;
    localparam int NDREG  = NSTG - 1;

    typedef logic [EW-1:0] err_t;
    typedef err_t [NK-1:0][NC-1:0] dtab_t;
    typedef err_t [LEVELS-1:0][PAT_BITS:0] vrow_t;
    typedef vrow_t [NUM_HEADS-1:0] vtab_t;

    function automatic err_t emax(err_t a, err_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic err_t emin(err_t a, err_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic err_t absdiff(err_t a, err_t b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic [NSTG-1:0]          vld_reg;
    meta_t                    meta_reg [NSTG];
    dtab_t                    d_reg    [NDREG];
    vtab_t                    v_reg    [BACK+2];
    err_t [NUM_HEADS-1:0]     t_reg;
    err_t                     est_reg  [BACK];
    vrow_t                    vsel_reg [BACK];
    logic [CW-1:0]            cnt_reg  [BACK];
    logic [PAT_BITS-1:0]      pat_reg  [BACK+1];

    dtab_t                    d_next;
    vtab_t                    v_b_next;
    err_t [NUM_HEADS-1:0]     t_next;
    err_t                     est_next;
    logic [HEAD_BITS-1:0]     head_next;
    logic [CW-1:0]            cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0] <= in_meta;
            for (int s = 1; s < NSTG; s++)
            begin
                meta_reg[s] <= meta_reg[s-1];
            end
            d_reg[0] <= d_next;
            for (int s = 1; s < NDREG; s++)
            begin
                d_reg[s] <= d_reg[s-1];
            end
        end
    end

    // Error table: |k*rem - c*den| for every bit count k and clock-extra count c.
    always_comb
    begin
        for (int k = 0; k < NK; k++)
        begin
            for (int c = 0; c < NC; c++)
            begin
                d_next[k][c] = absdiff(EW'(rem) * EW'(k + 1), EW'(den) * EW'(c));
            end
        end
    end

    // Worst error over the frame bits that reuse the head of the pattern.
    always_comb
    begin
        err_t                 m;
        logic [CW-1:0]        cnt;
        logic [HEAD_BITS-1:0] hb;
        v_b_next = '0;
        for (int h = 0; h < NUM_HEADS; h++)
        begin
            hb = HEAD_BITS'(h);
            for (int c = 0; c <= PAT_BITS; c++)
            begin
                m   = '0;
                cnt = CW'(c);
                for (int t = 0; t < HEAD_BITS; t++)
                begin
                    cnt = cnt + CW'(hb[HEAD_BITS-1-t]);
                    m   = emax(m, d_reg[0][PAT_BITS+t][cnt]);
                end
                v_b_next[h][LEVELS-1][c] = m;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg[0] <= v_b_next;
        end
    end

    // Backward pass: best reachable worst error from each bit position and count.
    for (genvar i = 0; i < BACK; i++)
    begin : g_back
        localparam int J = PAT_BITS - 1 - i;
        localparam int L = BACK - 1 - i;
        vtab_t vn;

        always_comb
        begin
            vn = v_reg[i];
            for (int h = 0; h < NUM_HEADS; h++)
            begin
                for (int c = 0; c < PAT_BITS; c++)
                begin
                    vn[h][L][c] = emin(emax(d_reg[SBK0+i-1][J][c], v_reg[i][h][L+1][c]),
                                       emax(d_reg[SBK0+i-1][J][c+1],
                                            v_reg[i][h][L+1][c+1]));
                end
                vn[h][L][PAT_BITS] = '1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_reg[i+1] <= vn;
            end
        end
    end

    // Total worst error for each head.
    always_comb
    begin
        err_t                 m;
        logic [CW-1:0]        cnt;
        logic [HEAD_BITS-1:0] hb;
        for (int h = 0; h < NUM_HEADS; h++)
        begin
            hb  = HEAD_BITS'(h);
            m   = '0;
            cnt = '0;
            for (int t = 0; t < HEAD_BITS; t++)
            begin
                cnt = cnt + CW'(hb[HEAD_BITS-1-t]);
                m   = emax(m, d_reg[ST-1][t][cnt]);
            end
            t_next[h] = emax(m, v_reg[BACK][h][0][cnt]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg         <= t_next;
            v_reg[BACK+1] <= v_reg[BACK];
        end
    end

    // Lowest head that reaches the minimum; ties go to the lower pattern.
    always_comb
    begin
        est_next  = t_reg[0];
        head_next = '0;
        for (int h = 1; h < NUM_HEADS; h++)
        begin
            if (t_reg[h] < est_next)
            begin
                est_next  = t_reg[h];
                head_next = HEAD_BITS'(h);
            end
        end
        cnt_next = '0;
        for (int t = 0; t < HEAD_BITS; t++)
        begin
            cnt_next = cnt_next + CW'(head_next[t]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            est_reg[0]  <= est_next;
            vsel_reg[0] <= v_reg[BACK+1][head_next];
            cnt_reg[0]  <= cnt_next;
            pat_reg[0]  <= {head_next, {BACK{1'b0}}};
        end
    end

    // Forward pass: take a zero bit whenever it still meets the optimum.
    for (genvar i = 0; i < BACK; i++)
    begin : g_fwd
        localparam int J = HEAD_BITS + i;
        err_t                x0;
        logic                bit_one;
        logic [PAT_BITS-1:0] pat_n;

        always_comb
        begin
            x0               = emax(d_reg[SF0+i-1][J][cnt_reg[i]], vsel_reg[i][i+1][cnt_reg[i]]);
            bit_one          = (x0 > est_reg[i]);
            pat_n            = pat_reg[i];
            pat_n[BACK-1-i]  = bit_one;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pat_reg[i+1] <= pat_n;
            end
        end

        if (i < BACK - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    est_reg[i+1]  <= est_reg[i];
                    vsel_reg[i+1] <= vsel_reg[i];
                    cnt_reg[i+1]  <= cnt_reg[i] + CW'(bit_one);
                end
            end
        end
    end

    assign out_valid  = vld_reg[NSTG-1];
    assign out_meta   = meta_reg[NSTG-1];
    assign second_mod = (meta_reg[NSTG-1].status == ST_OK) ? pat_reg[BACK] : '0;

endmodule
